// ===== rtl/assert_macros.svh =====
// Assertion macros for the window control RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== rtl/srwc_pkg.sv =====
// Types and codes for the selective-repeat window control unit.
// No dependencies.
package srwc_pkg;
   localparam int MAX_SEQ_NUM = 15;
   localparam int NR_BUFS = (MAX_SEQ_NUM + 1) / 2;
   localparam int SEQ_MOD = MAX_SEQ_NUM + 1;

   localparam logic [2:0] CMD_PACKET = 3'd0;
   localparam logic [2:0] CMD_PHY = 3'd1;
   localparam logic [2:0] CMD_FRAME = 3'd2;
   localparam logic [2:0] CMD_DATA_TO = 3'd3;
   localparam logic [2:0] CMD_ACK_TO = 3'd4;

   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_NAK = 2'd2;

   localparam logic [2:0] ACT_STATUS = 3'd0;
   localparam logic [2:0] ACT_SEND_DATA = 3'd1;
   localparam logic [2:0] ACT_SEND_ACK = 3'd2;
   localparam logic [2:0] ACT_SEND_NAK = 3'd3;
   localparam logic [2:0] ACT_STORE = 3'd4;
   localparam logic [2:0] ACT_DELIVER = 3'd5;
   localparam logic [2:0] ACT_STOP_TIMER = 3'd6;

   localparam logic [1:0] TIMER_KEEP = 2'd0;
   localparam logic [1:0] TIMER_START = 2'd1;
   localparam logic [1:0] TIMER_STOP = 2'd2;

   typedef struct packed {
      logic [2:0] cmd;
      logic       crc_ok;
      logic [1:0] frame_kind;
      logic [3:0] frame_seq;
      logic [3:0] piggy_ack;
      logic [2:0] timer_slot;
   } req_type;

   typedef struct packed {
      logic [2:0] action;
      logic [3:0] seq_num;
      logic [3:0] ack_num;
      logic [2:0] slot;
      logic [1:0] ack_timer_op;
      logic       network_enable;
      logic       last;
   } rsp_type;
endpackage

// ===== rtl/srwc_queue.sv =====
// Small event queue between the front end and the window engine.
// Depends on srwc_pkg.
module srwc_queue #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  srwc_pkg::req_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output srwc_pkg::req_type out_data
);
   import srwc_pkg::*;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   req_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0] cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready = cnt_ff != (AW+1)'(DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_data = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (pop) rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= in_data;
   end
endmodule

// ===== rtl/srwc_engine.sv =====
// Window engine: walks one event at a time, at most one command a cycle while the output register is free.
// Depends on srwc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module srwc_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             ev_valid,
   output logic             ev_ready,
   input  srwc_pkg::req_type ev_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output srwc_pkg::rsp_type rsp_data
);
   import srwc_pkg::*;
   localparam int SW = 4;
   localparam int BW = (NR_BUFS > 1) ? $clog2(NR_BUFS) : 1;
   localparam logic [SW-1:0] MAXS = SW'(MAX_SEQ_NUM);

   typedef enum logic [2:0] {
      S_IDLE, S_FIRST, S_STORE, S_DELIVER, S_RESEND, S_STOP, S_STATUS
   } state_type;

   state_type state_ff;
   req_type ev_ff;
   logic [SW-1:0] sl_ff, sn_ff, rl_ff, ru_ff, out_ff;
   logic nak_ff, phy_ff;
   logic [NR_BUFS-1:0] arr_ff;
   logic [4:0] cnt_ff;
   logic [BW:0] dcnt_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   function automatic logic [SW-1:0] inc(input logic [SW-1:0] k);
      return (k < MAXS) ? k + 1'b1 : '0;
   endfunction
   function automatic logic inwin(input logic [SW-1:0] a, b, c);
      return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
   endfunction
   function automatic logic [BW-1:0] slotof(input logic [SW-1:0] s);
      return BW'(s % SW'(NR_BUFS));
   endfunction

   logic [SW-1:0] fseq, fack, ackv, rs, tslot, dto_seq;
   assign fseq = ev_ff.frame_seq;
   assign fack = ev_ff.piggy_ack;
   assign ackv = (rl_ff == '0) ? MAXS : rl_ff - 1'b1;
   assign rs = inc(fack);
   assign tslot = {1'b0, ev_ff.timer_slot};
   // Outside the send window the expired slot belongs to the upper half.
   assign dto_seq = inwin(sl_ff, tslot, sn_ff) ? tslot : tslot + SW'(NR_BUFS);

   // Output slot is free when empty or being taken this cycle.
   logic emit_ok;
   assign emit_ok = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign ev_ready = (state_ff == S_IDLE);

   function automatic rsp_type mk(input logic [2:0] a, input logic [SW-1:0] s, q,
                                  input logic [BW-1:0] sl, input logic [1:0] t);
      rsp_type r;
      r = '0;
      r.action = a; r.seq_num = s; r.ack_num = q; r.slot = 3'(sl); r.ack_timer_op = t;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sl_ff <= '0; sn_ff <= '0; rl_ff <= '0; ru_ff <= SW'(NR_BUFS);
         out_ff <= '0; nak_ff <= 1'b1; phy_ff <= 1'b0; arr_ff <= '0;
         rsp_valid_ff <= 1'b0; cnt_ff <= '0; dcnt_ff <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (ev_valid) begin
                  ev_ff <= ev_data;
                  state_ff <= S_FIRST;
               end
            end
            S_FIRST: if (emit_ok) begin
               cnt_ff <= '0;
               dcnt_ff <= '0;
               state_ff <= S_STATUS;
               case (ev_ff.cmd)
                  CMD_PACKET: if (out_ff < SW'(NR_BUFS)) begin
                     out_ff <= out_ff + 1'b1;
                     rsp_ff <= mk(ACT_SEND_DATA, sn_ff, ackv, slotof(sn_ff), TIMER_STOP);
                     rsp_valid_ff <= 1'b1;
                     sn_ff <= inc(sn_ff);
                  end
                  CMD_PHY: phy_ff <= 1'b1;
                  CMD_FRAME: begin
                     if (!ev_ff.crc_ok) begin
                        if (nak_ff) begin
                           rsp_ff <= mk(ACT_SEND_NAK, '0, ackv, '0, TIMER_STOP);
                           rsp_valid_ff <= 1'b1;
                           nak_ff <= 1'b0;
                        end
                     end else begin
                        if (ev_ff.frame_kind == KIND_DATA) begin
                           rsp_valid_ff <= 1'b1;
                           if (fseq != rl_ff && nak_ff) begin
                              rsp_ff <= mk(ACT_SEND_NAK, '0, ackv, '0, TIMER_STOP);
                              nak_ff <= 1'b0;
                           end else begin
                              rsp_ff <= mk(ACT_STATUS, '0, '0, '0, TIMER_START);
                           end
                           state_ff <= S_STORE;
                        end else begin
                           state_ff <= S_RESEND;
                        end
                     end
                  end
                  CMD_DATA_TO: begin
                     rsp_ff <= mk(ACT_SEND_DATA, dto_seq, ackv, slotof(dto_seq), TIMER_STOP);
                     rsp_valid_ff <= 1'b1;
                  end
                  CMD_ACK_TO: begin
                     rsp_ff <= mk(ACT_SEND_ACK, '0, ackv, '0, TIMER_STOP);
                     rsp_valid_ff <= 1'b1;
                  end
                  default: ;
               endcase
            end
            S_STORE: if (emit_ok) begin
               if (inwin(rl_ff, fseq, ru_ff) && !arr_ff[slotof(fseq)]) begin
                  arr_ff[slotof(fseq)] <= 1'b1;
                  rsp_ff <= mk(ACT_STORE, fseq, '0, slotof(fseq), TIMER_KEEP);
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_DELIVER;
               end else begin
                  state_ff <= S_STOP;
               end
            end
            S_DELIVER: if (emit_ok) begin
               if (dcnt_ff < (BW+1)'(NR_BUFS) && arr_ff[slotof(rl_ff)]) begin
                  rsp_ff <= mk(ACT_DELIVER, rl_ff, '0, slotof(rl_ff), TIMER_START);
                  rsp_valid_ff <= 1'b1;
                  nak_ff <= 1'b1;
                  arr_ff[slotof(rl_ff)] <= 1'b0;
                  rl_ff <= inc(rl_ff);
                  ru_ff <= inc(ru_ff);
                  dcnt_ff <= dcnt_ff + 1'b1;
               end else begin
                  state_ff <= S_STOP;
               end
            end
            S_RESEND: if (emit_ok) begin
               if (ev_ff.frame_kind == KIND_NAK && inwin(sl_ff, rs, sn_ff)) begin
                  rsp_ff <= mk(ACT_SEND_DATA, rs, ackv, slotof(rs), TIMER_STOP);
                  rsp_valid_ff <= 1'b1;
               end
               state_ff <= S_STOP;
            end
            S_STOP: if (emit_ok) begin
               if (cnt_ff < 5'(SEQ_MOD) && inwin(sl_ff, fack, sn_ff)) begin
                  if (out_ff != '0) out_ff <= out_ff - 1'b1;
                  rsp_ff <= mk(ACT_STOP_TIMER, '0, '0, slotof(sl_ff), TIMER_KEEP);
                  rsp_valid_ff <= 1'b1;
                  sl_ff <= inc(sl_ff);
                  cnt_ff <= cnt_ff + 1'b1;
               end else begin
                  state_ff <= S_STATUS;
               end
            end
            S_STATUS: if (emit_ok) begin
               rsp_ff <= '0;
               rsp_ff.network_enable <= (out_ff < SW'(NR_BUFS)) && phy_ff;
               rsp_ff.last <= 1'b1;
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `ASSERT_IMPLIES(a_out_bound, clock, reset, 1'b1, out_ff <= SW'(NR_BUFS),
      "outstanding count above window")
   `ASSERT_IMPLIES(a_net_on_last, clock, reset, rsp_valid_ff && rsp_ff.network_enable,
      rsp_ff.last, "network enable on non-final item")
   `ASSERT_NEXT(a_take_event, clock, reset, ev_valid && ev_ready, state_ff == S_FIRST,
      "accepted event not started")
endmodule

// ===== rtl/selective_repeat_window_control_unit.sv =====
// Top level of the selective-repeat ARQ window control unit.
// Depends on srwc_pkg, srwc_queue and srwc_engine.
//
// Usage:
//   req_ carries one event (packet ready, phy ready, frame received,
//   data timeout, ack timeout). It lands in a QUEUE_DEPTH-entry queue, so the
//   front end keeps taking requests while the engine walks a window.
//   rsp_ carries the commands of each event in order; the final item is
//   a status item with last set and the network-enable flag.
//   Order: an accepted event waits in the queue, is taken into the engine's
//   event register when the engine is idle, and its first command is then
//   written to the output register. The engine issues at most one command a
//   cycle from its output register while the receiver takes it; the most
//   commands come from a data frame whose delivery and timer-stop walks each
//   cover the whole window (19 commands).
//   Reset: windows return to their start edges, the arrived map clears,
//   NAK is allowed and the physical layer is not ready.
//   A stalled receiver holds the output register and the walk; the queue
//   fills and then drops req_ready.
module selective_repeat_window_control_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  srwc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output srwc_pkg::rsp_type rsp_data
);
   import srwc_pkg::*;
   req_type q_data;
   logic q_valid, q_ready;

   // Hold events until the engine is free.
   srwc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready), .in_data(req_data),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   // Advance the windows at most one command a cycle, while the output is taken.
   srwc_engine u_engine (
      .clock(clock), .reset(reset),
      .ev_valid(q_valid), .ev_ready(q_ready), .ev_data(q_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );
endmodule
